### rtl/riff_wave_pcm_stream_parser_macros.svh
// ----------------------------------------------------------------------------
// riff wave pcm stream parser assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef RIFF_WAVE_PCM_STREAM_PARSER_MACROS_SVH
`define RIFF_WAVE_PCM_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define RWP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwp assertion failed");

// next-cycle implication
`define RWP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwp assertion failed");

`endif

### rtl/rwp_pkg.sv
// ----------------------------------------------------------------------------
// rwp_pkg
// types and constants of the riff wave pcm stream parser
// ----------------------------------------------------------------------------
package rwp_pkg;

  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [31:0] FmtMinLen   = 32'd16;
  localparam logic [15:0] FmtPcmCode  = 16'd1;
  localparam logic [15:0] FmtChannels = 16'd1;
  localparam logic [15:0] FmtBits     = 16'd16;

  typedef enum logic [3:0] {
    PhRiff  = 4'd0,
    PhRsize = 4'd1,
    PhWave  = 4'd2,
    PhTag   = 4'd3,
    PhCsize = 4'd4,
    PhFmt   = 4'd5,
    PhFskip = 4'd6,
    PhSkip  = 4'd7,
    PhData  = 4'd8,
    PhEnd   = 4'd9
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StEarlyEnd = 3'd1,
    StNotRiff  = 3'd2,
    StNotWave  = 3'd3,
    StBadFmt   = 3'd4,
    StUnsup    = 3'd5,
    StBadData  = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       is_final;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               sample_valid;
    logic               finished;
    logic [2:0]         status;
    logic [31:0]        rate_found;
  } out_t;

endpackage

### rtl/rwp_parse.sv
// ----------------------------------------------------------------------------
// rwp_parse
// parser state and per-byte next-state logic, one byte per enabled cycle
// ----------------------------------------------------------------------------
module rwp_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  rwp_pkg::in_t  item_i,
  output rwp_pkg::out_t res_o,
  output logic          res_valid_o
);
  import rwp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  fbc_q, fbc_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [15:0] fcode_q, fcode_d;
  logic [15:0] chans_q, chans_d;
  logic [15:0] sbits_q, sbits_d;
  logic [31:0] rate_q, rate_d;
  logic        seen_q, seen_d;
  logic [7:0]  low_q, low_d;

  logic [7:0]  b;
  logic [31:0] tag_next;
  logic [31:0] len_next;
  logic [31:0] rate_next;
  logic [15:0] sbits_full;
  logic        fmt_ok;
  logic        done;
  logic        got_sample;
  status_e     st;

  assign b          = item_i.file_byte;
  assign tag_next   = {tag_q[23:0], b};
  assign sbits_full = {b, sbits_q[7:0]};
  assign fmt_ok     = (fcode_q == FmtPcmCode) && (chans_q == FmtChannels) &&
                      (sbits_full == FmtBits);

  always_comb begin
    case (fbc_q[1:0])
      2'd0:    len_next = {24'd0, b};
      2'd1:    len_next = len_q | {16'd0, b, 8'd0};
      2'd2:    len_next = len_q | {8'd0, b, 16'd0};
      default: len_next = len_q | {b, 24'd0};
    endcase
  end

  // sample rate bytes of the fmt chunk
  always_comb begin
    rate_next = rate_q;
    if (phase_q == PhFmt) begin
      case (fbc_q)
        4'd4:    rate_next = {24'd0, b};
        4'd5:    rate_next = rate_q | {16'd0, b, 8'd0};
        4'd6:    rate_next = rate_q | {8'd0, b, 16'd0};
        4'd7:    rate_next = rate_q | {b, 24'd0};
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    fbc_d   = fbc_q;
    tag_d   = tag_q;
    len_d   = len_q;
    fcode_d = fcode_q;
    chans_d = chans_q;
    sbits_d = sbits_q;
    rate_d  = rate_q;
    seen_d  = seen_q;
    low_d   = low_q;
    case (phase_q)
      PhRiff, PhWave, PhTag: begin
        tag_d = tag_next;
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd3) begin
          fbc_d = '0;
          case (phase_q)
            PhRiff:  phase_d = PhRsize;
            PhWave:  phase_d = PhTag;
            default: phase_d = PhCsize;
          endcase
        end
      end
      PhRsize: begin
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd3) begin
          fbc_d   = '0;
          phase_d = PhWave;
        end
      end
      PhCsize: begin
        len_d = len_next;
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd3) begin
          fbc_d = '0;
          if (tag_q == TagFmt) begin
            phase_d = PhFmt;
          end else if (tag_q == TagData) begin
            phase_d = (len_next == '0) ? PhTag : PhData;
          end else begin
            fbc_d   = {3'd0, len_next[0]};
            phase_d = (len_next == '0) ? PhTag : PhSkip;
          end
        end
      end
      PhFmt: begin
        rate_d = rate_next;
        case (fbc_q)
          4'd0:    fcode_d = {8'd0, b};
          4'd1:    fcode_d = {b, fcode_q[7:0]};
          4'd2:    chans_d = {8'd0, b};
          4'd3:    chans_d = {b, chans_q[7:0]};
          4'd14:   sbits_d = {8'd0, b};
          4'd15:   sbits_d = sbits_full;
          default: ;
        endcase
        fbc_d = fbc_q + 4'd1;
        if (fbc_q == 4'd15) begin
          fbc_d   = '0;
          seen_d  = 1'b1;
          len_d   = len_q - FmtMinLen;
          phase_d = (len_q == FmtMinLen) ? PhTag : PhFskip;
        end
      end
      PhFskip: begin
        len_d = len_q - 32'd1;
        if (len_q == 32'd1) phase_d = PhTag;
      end
      PhSkip: begin
        if (len_q != '0) begin
          len_d = len_q - 32'd1;
        end else begin
          fbc_d = '0;
        end
        if ((len_q == '0) || ((len_q == 32'd1) && (fbc_q == '0))) phase_d = PhTag;
      end
      PhData: begin
        if (!fbc_q[0]) begin
          low_d = b;
          fbc_d = 4'd1;
        end else begin
          fbc_d = '0;
        end
        len_d = len_q - 32'd1;
      end
      default: ;
    endcase
    if (done) phase_d = PhEnd;
  end

  // outputs
  always_comb begin
    done       = 1'b0;
    got_sample = 1'b0;
    st         = StOk;
    case (phase_q)
      PhRiff: begin
        if ((fbc_q == 4'd3) && (tag_next != TagRiff)) begin
          done = 1'b1;
          st   = StNotRiff;
        end
      end
      PhWave: begin
        if ((fbc_q == 4'd3) && (tag_next != TagWave)) begin
          done = 1'b1;
          st   = StNotWave;
        end
      end
      PhCsize: begin
        if (fbc_q == 4'd3) begin
          if ((tag_q == TagFmt) && (len_next < FmtMinLen)) begin
            done = 1'b1;
            st   = StBadFmt;
          end else if ((tag_q == TagData) && (!seen_q || len_next[0])) begin
            done = 1'b1;
            st   = StBadData;
          end
        end
      end
      PhFmt: begin
        if ((fbc_q == 4'd15) && !fmt_ok) begin
          done = 1'b1;
          st   = StUnsup;
        end
      end
      PhData: begin
        got_sample = fbc_q[0];
        if (len_q == 32'd1) begin
          done = 1'b1;
          st   = StOk;
        end
      end
      default: ;
    endcase
    if (!done && item_i.is_final && (phase_q != PhEnd)) begin
      done = 1'b1;
      st   = StEarlyEnd;
    end
    res_o.pcm_sample   = got_sample ? {b, low_q} : '0;
    res_o.sample_valid = got_sample;
    res_o.finished     = done;
    res_o.status       = done ? st : StOk;
    res_o.rate_found   = rate_next;
    res_valid_o        = step_i && (phase_q != PhEnd) && (got_sample || done);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhRiff;
      fbc_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      fcode_q <= '0;
      chans_q <= '0;
      sbits_q <= '0;
      rate_q  <= '0;
      seen_q  <= 1'b0;
      low_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      fbc_q   <= fbc_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      fcode_q <= fcode_d;
      chans_q <= chans_d;
      sbits_q <= sbits_d;
      rate_q  <= rate_d;
      seen_q  <= seen_d;
      low_q   <= low_d;
    end
  end

endmodule

### rtl/riff_wave_pcm_stream_parser.sv
// ----------------------------------------------------------------------------
// riff_wave_pcm_stream_parser
// byte-wide wav parser giving mono 16-bit pcm samples and a final status
// ----------------------------------------------------------------------------
// Takes one file byte per cycle unless held by the result side; a byte passes
// an input register, then the parser logic, then the result register, so a
// result word is registered when the parser steps on its byte. The rate is
// set by the single parser stage, which updates counters and shift registers
// once per byte; a result word that waits for out_ready_i holds the parser
// and the byte behind it. A result word leaves for every completed sample and
// once when parsing ends; bytes after the end are taken and dropped until reset.
module riff_wave_pcm_stream_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rwp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rwp_pkg::out_t out_data_o
);
  import rwp_pkg::*;

  in_t  in_q;
  logic in_valid_q;
  out_t out_q;
  logic out_valid_q;
  out_t res;
  logic res_valid;
  logic step;

  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  rwp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_q),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/rwp_checker.sv
// ----------------------------------------------------------------------------
// rwp_checker
// port-level checks of the riff wave pcm stream parser, bound to the top
// ----------------------------------------------------------------------------
`include "riff_wave_pcm_stream_parser_macros.svh"

module rwp_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input rwp_pkg::out_t out_data_o
);
  import rwp_pkg::*;

  logic held;
  logic end_taken;
  logic empty_word;
  logic mid_word;
  logic no_sample;

  assign held       = out_valid_o && !out_ready_i;
  assign end_taken  = out_valid_o && out_ready_i && out_data_o.finished;
  assign empty_word = out_valid_o && !out_data_o.sample_valid && !out_data_o.finished;
  assign mid_word   = out_valid_o && !out_data_o.finished;
  assign no_sample  = out_valid_o && !out_data_o.sample_valid;

  `RWP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_o && $stable(out_data_o))
  `RWP_ASSERT_NEXT(a_nothing_after_end, clk_i, rst_ni, end_taken, !out_valid_o)
  `RWP_ASSERT_NOW(a_word_not_empty, clk_i, rst_ni, out_valid_o, !empty_word)
  `RWP_ASSERT_NOW(a_status_only_at_end, clk_i, rst_ni, mid_word, out_data_o.status == StOk)
  `RWP_ASSERT_NOW(a_sample_zero_when_none, clk_i, rst_ni, no_sample, out_data_o.pcm_sample == '0)

endmodule

bind riff_wave_pcm_stream_parser rwp_checker u_rwp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### test/riff_wave_pcm_stream_parser_test.sv
// ----------------------------------------------------------------------------
// riff_wave_pcm_stream_parser_test
// Streams one generated wav file through the parser, byte by byte, with
// random gaps on the byte side and random stalls on the result side. Each
// run picks a file shape at random: a clean file, a file cut short in the
// header or in the samples, or a file with one header fault. Bytes after
// the end of parsing are sent as well and must give no word. A byte-level
// predictor builds the expected result words, which are compared field by
// field with the words that come out.
// ----------------------------------------------------------------------------
module riff_wave_pcm_stream_parser_test;
  import rwp_pkg::*;

  localparam int IdleLimit = 2000;
  localparam logic [31:0] TagJunk = 32'h4A55_4E4B;

  typedef enum int {
    ShapeFull,
    ShapeFinalOnLast,
    ShapeCutInData,
    ShapeBadRiff,
    ShapeBadWave,
    ShapeShortFmt,
    ShapeBadFormat,
    ShapeDataFirst,
    ShapeOddData,
    ShapeCutInHeader,
    ShapeEndlessChunk
  } shape_e;

  typedef enum int {
    SpoilNone,
    SpoilCode,
    SpoilChannels,
    SpoilBits
  } spoil_e;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  in_t    in_data_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  out_t   out_data_o;

  in_t    file_bytes[$];
  out_t   expected_words[$];
  int     total_bytes = 0;
  int     bytes_sent = 0;
  int     words_checked = 0;
  int     samples_seen = 0;
  int     mismatches = 0;
  int     idle_cycles = 0;
  int     send_gap = 0;
  int     take_gap = 0;
  bit     send_burst = 1'b0;
  bit     take_burst = 1'b0;
  shape_e shape;

  // parser state of the predictor
  phase_e      phase = PhRiff;
  logic [31:0] fld_cnt = '0;
  logic [31:0] tag_sr = '0;
  logic [31:0] chunk_left = '0;
  logic [15:0] fmt_code = '0;
  logic [15:0] chan_cnt = '0;
  logic [15:0] bits_per = '0;
  logic [31:0] rate_reg = '0;
  logic        fmt_ok = 1'b0;
  logic [7:0]  lo_hold = '0;
  logic        parse_done = 1'b0;

  riff_wave_pcm_stream_parser u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic parse_byte(input in_t item);
    logic [7:0]  b;
    logic        got;
    logic        ended;
    status_e     st;
    logic [15:0] smp;
    out_t        w;
    b = item.file_byte;
    got = 1'b0;
    ended = 1'b0;
    st = StOk;
    smp = '0;
    if (!parse_done) begin
      case (phase)
        PhRiff, PhWave, PhTag: begin
          tag_sr = {tag_sr[23:0], b};
          fld_cnt++;
          if (fld_cnt >= 4) begin
            fld_cnt = 0;
            if (phase == PhRiff) begin
              if (tag_sr != TagRiff) begin
                ended = 1'b1;
                st = StNotRiff;
              end else begin
                phase = PhRsize;
              end
            end else if (phase == PhWave) begin
              if (tag_sr != TagWave) begin
                ended = 1'b1;
                st = StNotWave;
              end else begin
                phase = PhTag;
              end
            end else begin
              phase = PhCsize;
            end
          end
        end
        PhRsize: begin
          fld_cnt++;
          if (fld_cnt >= 4) begin
            fld_cnt = 0;
            phase = PhWave;
          end
        end
        PhCsize: begin
          if (fld_cnt[1:0] == 2'd0) chunk_left = 32'(b);
          else chunk_left[8*fld_cnt[1:0] +: 8] = b;
          fld_cnt++;
          if (fld_cnt >= 4) begin
            fld_cnt = 0;
            if (tag_sr == TagFmt) begin
              if (chunk_left < FmtMinLen) begin
                ended = 1'b1;
                st = StBadFmt;
              end else begin
                phase = PhFmt;
              end
            end else if (tag_sr == TagData) begin
              if (!fmt_ok || chunk_left[0]) begin
                ended = 1'b1;
                st = StBadData;
              end else if (chunk_left == 0) begin
                phase = PhTag;
              end else begin
                phase = PhData;
              end
            end else begin
              // pad byte still owed on odd size
              fld_cnt = {31'b0, chunk_left[0]};
              if (chunk_left == 0) phase = PhTag;
              else phase = PhSkip;
            end
          end
        end
        PhFmt: begin
          case (fld_cnt)
            0:  fmt_code = {8'h00, b};
            1:  fmt_code[15:8] = b;
            2:  chan_cnt = {8'h00, b};
            3:  chan_cnt[15:8] = b;
            4:  rate_reg = 32'(b);
            5:  rate_reg[15:8] = b;
            6:  rate_reg[23:16] = b;
            7:  rate_reg[31:24] = b;
            14: bits_per = {8'h00, b};
            15: bits_per[15:8] = b;
            default: ;
          endcase
          fld_cnt++;
          if (fld_cnt >= 16) begin
            fld_cnt = 0;
            if (fmt_code != FmtPcmCode || chan_cnt != FmtChannels || bits_per != FmtBits) begin
              ended = 1'b1;
              st = StUnsup;
            end else begin
              fmt_ok = 1'b1;
              chunk_left -= FmtMinLen;
              if (chunk_left == 0) phase = PhTag;
              else phase = PhFskip;
            end
          end
        end
        PhFskip: begin
          chunk_left--;
          if (chunk_left == 0) phase = PhTag;
        end
        PhSkip: begin
          if (chunk_left != 0) chunk_left--;
          else fld_cnt = 0;
          if (chunk_left == 0 && fld_cnt == 0) phase = PhTag;
        end
        PhData: begin
          if (!fld_cnt[0]) begin
            lo_hold = b;
            fld_cnt = 1;
          end else begin
            smp = {b, lo_hold};
            got = 1'b1;
            fld_cnt = 0;
          end
          chunk_left--;
          if (chunk_left == 0) begin
            ended = 1'b1;
            st = StOk;
          end
        end
        default: ;
      endcase
      if (!ended && item.is_final) begin
        ended = 1'b1;
        st = StEarlyEnd;
      end
      if (ended) begin
        parse_done = 1'b1;
        phase = PhEnd;
      end
      if (got || ended) begin
        w.pcm_sample = smp;
        w.sample_valid = got;
        w.finished = ended;
        w.status = st;
        w.rate_found = rate_reg;
        expected_words = {expected_words, w};
      end
    end
  endtask

  task automatic put_byte(input logic [7:0] b);
    in_t w;
    w.file_byte = b;
    w.is_final = 1'b0;
    file_bytes = {file_bytes, w};
  endtask

  task automatic put_tag(input logic [31:0] t);
    for (int i = 3; i >= 0; i--) put_byte(t[8*i +: 8]);
  endtask

  task automatic put_le16(input logic [15:0] v);
    put_byte(v[7:0]);
    put_byte(v[15:8]);
  endtask

  task automatic put_le32(input logic [31:0] v);
    put_le16(v[15:0]);
    put_le16(v[31:16]);
  endtask

  task automatic put_unknown(input logic [31:0] len);
    logic [31:0] t;
    t = $urandom;
    while (t == TagFmt || t == TagData) t = $urandom;
    put_tag(t);
    put_le32(len);
    for (int i = 0; i < len; i++) put_byte(8'($urandom));
    if (len[0]) put_byte(8'($urandom));
  endtask

  task automatic put_fmt(input logic [31:0] len, input spoil_e spoil);
    logic [15:0] code;
    logic [15:0] chans;
    logic [15:0] bits;
    code = FmtPcmCode;
    chans = FmtChannels;
    bits = FmtBits;
    case (spoil)
      SpoilCode:     code ^= 16'($urandom_range(1, 65535));
      SpoilChannels: chans ^= 16'($urandom_range(1, 65535));
      SpoilBits:     bits ^= 16'($urandom_range(1, 65535));
      default: ;
    endcase
    put_tag(TagFmt);
    put_le32(len);
    put_le16(code);
    put_le16(chans);
    put_le32($urandom);
    put_le32($urandom);
    put_le16(16'($urandom));
    put_le16(bits);
    for (int i = 16; i < len; i++) put_byte(8'($urandom));
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_word(input out_t got);
    out_t want;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = expected_words.pop_front();
      compare_field("pcm_sample", {16'h0, want.pcm_sample}, {16'h0, got.pcm_sample});
      compare_field("sample_valid", 32'(want.sample_valid), 32'(got.sample_valid));
      compare_field("finished", 32'(want.finished), 32'(got.finished));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("rate_found", want.rate_found, got.rate_found);
      words_checked++;
      if (got.sample_valid) samples_seen++;
    end
  endtask

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        parse_byte(in_data_i);
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0 || file_bytes.size() == 0) begin
          in_valid_i <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          in_valid_i <= 1'b1;
          in_data_i <= file_bytes.pop_front();
          if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 10);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_word(out_data_o);
        if ($urandom_range(0, 29) == 0) take_burst = !take_burst;
        take_gap = take_burst ? 0 : $urandom_range(0, 10);
      end
      if (take_gap > 0) begin
        out_ready_i <= 1'b0;
        take_gap--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] t;
    logic [31:0] flen;
    spoil_e      spoil;
    int          data_tag_at;
    int          data_first;
    int          data_last;
    int          cut;
    int          nsamp;
    in_t         w;

    case ($urandom_range(0, 15))
      0, 1, 2, 15: shape = ShapeFull;
      3, 4:        shape = ShapeFinalOnLast;
      5, 6:        shape = ShapeCutInData;
      7:           shape = ShapeBadRiff;
      8:           shape = ShapeBadWave;
      9:           shape = ShapeShortFmt;
      10:          shape = ShapeBadFormat;
      11:          shape = ShapeDataFirst;
      12:          shape = ShapeOddData;
      13:          shape = ShapeCutInHeader;
      default:     shape = ShapeEndlessChunk;
    endcase

    t = TagRiff;
    if (shape == ShapeBadRiff) t ^= 32'(1) << $urandom_range(0, 31);
    put_tag(t);
    put_le32($urandom);
    t = TagWave;
    if (shape == ShapeBadWave) t ^= 32'(1) << $urandom_range(0, 31);
    put_tag(t);
    if (shape == ShapeEndlessChunk) begin
      put_tag(TagJunk);
      put_le32(32'hFFFF_FFFF);
    end
    put_unknown(32'd3);
    put_unknown(32'd0);
    put_unknown(32'd1);
    repeat ($urandom_range(0, 3)) put_unknown($urandom_range(0, 9));
    if (shape == ShapeDataFirst) begin
      put_tag(TagData);
      put_le32(2 * $urandom_range(1, 4));
      repeat (8) put_byte(8'($urandom));
    end

    if (shape == ShapeShortFmt) flen = $urandom_range(0, 15);
    else if ($urandom_range(0, 1) == 0) flen = FmtMinLen;
    else flen = FmtMinLen + $urandom_range(1, 6);
    spoil = (shape == ShapeBadFormat) ? spoil_e'($urandom_range(1, 3)) : SpoilNone;
    put_fmt(flen, spoil);
    if ($urandom_range(0, 1) == 0) put_fmt(FmtMinLen + $urandom_range(0, 3), SpoilNone);
    if ($urandom_range(0, 1) == 0) begin
      put_tag(TagData);
      put_le32(32'd0);
    end
    if ($urandom_range(0, 1) == 0) put_unknown($urandom_range(0, 5));
    if (shape == ShapeOddData) begin
      put_tag(TagData);
      put_le32(2 * $urandom_range(0, 20) + 1);
    end

    data_tag_at = file_bytes.size();
    nsamp = $urandom_range(330, 390);
    put_tag(TagData);
    put_le32(2 * nsamp);
    data_first = file_bytes.size();
    put_le16(16'h8000);
    put_le16(16'h7FFF);
    put_le16(16'h0000);
    put_le16(16'hFFFF);
    repeat (nsamp - 4) put_le16(16'($urandom));
    data_last = file_bytes.size() - 1;

    case (shape)
      ShapeFinalOnLast, ShapeEndlessChunk: cut = data_last;
      ShapeCutInData:   cut = $urandom_range(data_first, data_last - 1);
      ShapeCutInHeader: cut = $urandom_range(0, data_tag_at - 1);
      default:          cut = -1;
    endcase
    if (cut >= 0) begin
      w = file_bytes[cut];
      w.is_final = 1'b1;
      file_bytes[cut] = w;
    end
    // trailing bytes after the end must be dropped
    repeat (16) begin
      w.file_byte = 8'($urandom);
      w.is_final = 1'($urandom);
      file_bytes = {file_bytes, w};
    end
    total_bytes = file_bytes.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (bytes_sent == total_bytes);
    wait (expected_words.size() == 0);
    repeat (30) @(posedge clk_i);

    $display("file shape %s: %0d bytes sent, %0d result words checked, %0d samples",
             shape.name(), bytes_sent, words_checked, samples_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
